// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TGAR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tile lookup assertion failed");

// Property checked on every clock edge, reset included.
`define TGAR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("tile lookup assertion failed during reset");

`endif

// ===== src/tgar_pkg.sv =====
// Package for the tile gid to atlas rectangle block: sizes, codes and types.
// Used by the top level and the checker; depends on nothing.
`default_nettype none
package tgar_pkg;
    localparam int TILESET_SLOTS  = 8;
    localparam int MAX_CHUNK_SIZE = 64;

    localparam int SLOT_W  = (TILESET_SLOTS > 1) ? $clog2(TILESET_SLOTS) : 1;
    localparam int COUNT_W = $clog2(TILESET_SLOTS + 1);
    localparam int CS_W    = $clog2(MAX_CHUNK_SIZE + 1);
    localparam int GID_W   = 29;
    localparam int F_W     = 12;
    localparam int SUM_W   = F_W + 1;
    localparam int CELL_W  = 16 + CS_W + 1;
    localparam int DST_W   = 36;
    localparam int SRC_W   = 26;
    localparam int PY_W    = GID_W + SUM_W;

    localparam logic [SRC_W-1:0] SRC_MAX = {SRC_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_APPEND    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_NONE      = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_DRAW      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_SET    = 3'd2,
        ST_ZERO_COLS = 3'd3,
        ST_TABLE_OK  = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_CHUNK_SIZE  = 2'd0,
        CFG_GRID_STEP_X = 2'd1,
        CFG_GRID_STEP_Y = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [GID_W-1:0] first_gid;
        logic [F_W-1:0]   tile_w;
        logic [F_W-1:0]   tile_h;
        logic [F_W-1:0]   columns;
        logic [F_W-1:0]   margin;
        logic [F_W-1:0]   spacing;
    } entry_t;

    typedef struct packed {
        status_t                  status;
        logic [GID_W-1:0]         first_gid;
        logic [GID_W-1:0]         dividend;
        logic [GID_W-1:0]         quo;
        logic [F_W-1:0]           rem;
        logic [F_W-1:0]           tile_w;
        logic [F_W-1:0]           tile_h;
        logic [F_W-1:0]           columns;
        logic [F_W-1:0]           margin;
        logic [F_W-1:0]           spacing;
        logic [SUM_W-1:0]         pitch_x;
        logic [SUM_W-1:0]         pitch_y;
        logic signed [15:0]       chunk_x;
        logic signed [15:0]       chunk_y;
        logic [5:0]               local_x;
        logic [5:0]               local_y;
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_y;
        logic [F_W+SUM_W-1:0]     prod_x;
        logic [PY_W-1:0]          prod_y;
        logic [DST_W-1:0]         dst_x;
        logic [DST_W-1:0]         dst_y;
        logic [SRC_W-1:0]         src_x;
        logic [SRC_W-1:0]         src_y;
        logic                     flip_h;
        logic                     flip_v;
    } pipe_t;
endpackage
`default_nettype wire

// ===== src/tile_gid_to_atlas_rect_top.sv =====
// Tile gid to atlas rectangle: a fully pipelined tile fetch address generator.
// Depends on tgar_pkg for sizes, codes and the pipeline word type.
//
// The block takes one input word per clock whenever the result side is ready
// and returns exactly one result word for each, in order. The depth of the
// pipe is set by the long quotient path: the tile index inside the
// tileset is split by the column count in a restoring divider that resolves
// one quotient bit per stage over 29 stages. Ahead of it, a first stage decodes
// the opcode, updates the tileset table and picks the last table entry whose
// first gid does not exceed the gid, and a second stage forms the tile index and
// the world cell. Behind it, one stage multiplies and a final stage adds,
// saturates and holds the result word. The whole pipe moves as one: it advances
// whenever the output register is empty or being taken, so a stall on the
// result side freezes every stage without losing or repeating a word. Table
// clear and append words are handled in the first stage and so are seen by
// every later translate word. Configuration writes are always taken at once and
// are meant to happen only while the pipe is empty.
`default_nettype none
module tile_gid_to_atlas_rect_top
    import tgar_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [F_W-1:0]           cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_opcode,
    input  wire logic [GID_W-1:0]         s_entry_first_gid,
    input  wire logic [F_W-1:0]           s_entry_tile_w,
    input  wire logic [F_W-1:0]           s_entry_tile_h,
    input  wire logic [F_W-1:0]           s_entry_columns,
    input  wire logic [F_W-1:0]           s_entry_margin,
    input  wire logic [F_W-1:0]           s_entry_spacing,
    input  wire logic [31:0]              s_tile_word,
    input  wire logic signed [15:0]       s_chunk_x,
    input  wire logic signed [15:0]       s_chunk_y,
    input  wire logic [5:0]               s_local_x,
    input  wire logic [5:0]               s_local_y,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [2:0]                    m_status,
    output logic [SRC_W-1:0]              m_src_x,
    output logic [SRC_W-1:0]              m_src_y,
    output logic [F_W-1:0]                m_src_w,
    output logic [F_W-1:0]                m_src_h,
    output logic signed [DST_W-1:0]       m_dst_x,
    output logic signed [DST_W-1:0]       m_dst_y,
    output logic                          m_flip_h,
    output logic                          m_flip_v
);
    // Stage map: decode, index, one stage per quotient bit, multiply, output.
    localparam int S_A  = 0;
    localparam int S_B  = 1;
    localparam int S_C  = 2 + GID_W;
    localparam int S_D  = S_C + 1;
    localparam int NST  = S_D + 1;

    logic [6:0]        chunk_size_reg;
    logic [F_W-1:0]    grid_step_x_reg;
    logic [F_W-1:0]    grid_step_y_reg;
    logic [COUNT_W-1:0] count_reg;
    entry_t            tab_reg [TILESET_SLOTS];

    logic              vld_reg   [NST];
    pipe_t             pipe_reg  [NST];
    pipe_t             pipe_next [NST];

    logic              adv;
    logic              acc;
    logic [CS_W-1:0]   cs_eff;

    // The pipe moves whenever the output register can take a new word.
    assign adv       = !vld_reg[S_D] || m_ready;
    assign s_ready   = adv;
    assign acc       = s_valid && adv;
    assign cfg_ready = 1'b1;

    // Chunk size is clamped into one to the largest supported chunk.
    always_comb begin
        if (chunk_size_reg == '0) begin
            cs_eff = CS_W'(1);
        end else if (32'(chunk_size_reg) > MAX_CHUNK_SIZE) begin
            cs_eff = CS_W'(MAX_CHUNK_SIZE);
        end else begin
            cs_eff = CS_W'(chunk_size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg  <= 7'd16;
            grid_step_x_reg <= F_W'(16);
            grid_step_y_reg <= F_W'(16);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data[6:0];
                CFG_GRID_STEP_X: grid_step_x_reg <= cfg_data;
                CFG_GRID_STEP_Y: grid_step_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Table count and entry writes happen as the word enters the pipe.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (acc) begin
            if (s_opcode == OP_CLEAR) begin
                count_reg <= '0;
            end else if (s_opcode == OP_APPEND && 32'(count_reg) < TILESET_SLOTS) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_opcode == OP_APPEND && 32'(count_reg) < TILESET_SLOTS) begin
            tab_reg[count_reg[SLOT_W-1:0]] <= '{first_gid: s_entry_first_gid,
                                               tile_w:    s_entry_tile_w,
                                               tile_h:    s_entry_tile_h,
                                               columns:   s_entry_columns,
                                               margin:    s_entry_margin,
                                               spacing:   s_entry_spacing};
        end
    end

    // Decode stage: opcode handling and the priority search over the table.
    always_comb begin
        logic [GID_W-1:0]  gid;
        logic              hit;
        logic [SLOT_W-1:0] sel;
        entry_t            ent;
        pipe_t             p;
        gid = s_tile_word[GID_W-1:0];
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < TILESET_SLOTS; i++) begin
            if (32'(i) < 32'(count_reg) && gid >= tab_reg[i].first_gid) begin
                hit = 1'b1;
                sel = SLOT_W'(i);
            end
        end
        ent = tab_reg[sel];
        p = '0;
        p.dividend  = gid;
        p.first_gid = ent.first_gid;
        p.tile_w    = ent.tile_w;
        p.tile_h    = ent.tile_h;
        p.columns   = ent.columns;
        p.margin    = ent.margin;
        p.spacing   = ent.spacing;
        p.chunk_x   = s_chunk_x;
        p.chunk_y   = s_chunk_y;
        p.local_x   = s_local_x;
        p.local_y   = s_local_y;
        p.flip_h    = s_tile_word[31];
        p.flip_v    = s_tile_word[30];
        case (s_opcode)
            OP_TRANSLATE: begin
                if (gid == '0) begin
                    p.status = ST_EMPTY;
                end else if (!hit) begin
                    p.status = ST_NO_SET;
                end else begin
                    p.status = ST_DRAW;
                end
            end
            OP_APPEND: begin
                p.status = (32'(count_reg) < TILESET_SLOTS) ? ST_TABLE_OK : ST_FULL;
            end
            default: p.status = ST_TABLE_OK;
        endcase
        pipe_next[S_A] = p;
    end

    // Index stage: tile index, atlas pitches and world cell coordinates.
    always_comb begin
        pipe_t p;
        p = pipe_reg[S_A];
        if (p.status == ST_DRAW && p.columns == '0) begin
            p.status = ST_ZERO_COLS;
        end
        p.dividend = p.dividend - p.first_gid;
        p.quo      = '0;
        p.rem      = '0;
        p.pitch_x  = {1'b0, p.tile_w} + {1'b0, p.spacing};
        p.pitch_y  = {1'b0, p.tile_h} + {1'b0, p.spacing};
        p.cell_x   = p.chunk_x * $signed({1'b0, cs_eff}) + $signed({1'b0, p.local_x});
        p.cell_y   = p.chunk_y * $signed({1'b0, cs_eff}) + $signed({1'b0, p.local_y});
        pipe_next[S_B] = p;
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < GID_W; k++) begin : g_div
        always_comb begin
            pipe_t            p;
            logic [SUM_W-1:0] trial;
            logic             qbit;
            p     = pipe_reg[S_B + k];
            trial = {p.rem, p.dividend[GID_W-1-k]};
            qbit  = (trial >= {1'b0, p.columns});
            if (qbit) begin
                p.rem = F_W'(trial - {1'b0, p.columns});
            end else begin
                p.rem = trial[F_W-1:0];
            end
            p.quo = {p.quo[GID_W-2:0], qbit};
            pipe_next[S_B + 1 + k] = p;
        end
    end

    // Multiply stage: atlas offsets and destination pixel offsets.
    always_comb begin
        pipe_t                       p;
        logic signed [CELL_W+F_W:0]  dx;
        logic signed [CELL_W+F_W:0]  dy;
        p  = pipe_reg[S_C - 1];
        p.prod_x = (F_W+SUM_W)'(p.rem) * (F_W+SUM_W)'(p.pitch_x);
        p.prod_y = PY_W'(p.quo) * PY_W'(p.pitch_y);
        dx = p.cell_x * $signed({1'b0, grid_step_x_reg});
        dy = p.cell_y * $signed({1'b0, grid_step_y_reg});
        p.dst_x = dx[DST_W-1:0];
        p.dst_y = dy[DST_W-1:0];
        pipe_next[S_C] = p;
    end

    // Output stage: margin add, saturation, and zeroed fields for non-draws.
    always_comb begin
        pipe_t           p;
        logic [PY_W:0]   sx;
        logic [PY_W:0]   sy;
        p  = pipe_reg[S_C];
        sx = (PY_W+1)'(p.margin) + (PY_W+1)'(p.prod_x);
        sy = (PY_W+1)'(p.margin) + (PY_W+1)'(p.prod_y);
        p.src_x = (sx > (PY_W+1)'(SRC_MAX)) ? SRC_MAX : sx[SRC_W-1:0];
        p.src_y = (sy > (PY_W+1)'(SRC_MAX)) ? SRC_MAX : sy[SRC_W-1:0];
        if (p.status != ST_DRAW) begin
            p.src_x  = '0;
            p.src_y  = '0;
            p.tile_w = '0;
            p.tile_h = '0;
            p.dst_x  = '0;
            p.dst_y  = '0;
            p.flip_h = 1'b0;
            p.flip_v = 1'b0;
        end
        pipe_next[S_D] = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[S_A] <= s_valid;
            for (int i = 1; i < NST; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NST; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    assign m_valid  = vld_reg[S_D];
    assign m_status = pipe_reg[S_D].status;
    assign m_src_x  = pipe_reg[S_D].src_x;
    assign m_src_y  = pipe_reg[S_D].src_y;
    assign m_src_w  = pipe_reg[S_D].tile_w;
    assign m_src_h  = pipe_reg[S_D].tile_h;
    assign m_dst_x  = $signed(pipe_reg[S_D].dst_x);
    assign m_dst_y  = $signed(pipe_reg[S_D].dst_y);
    assign m_flip_h = pipe_reg[S_D].flip_h;
    assign m_flip_v = pipe_reg[S_D].flip_v;
endmodule
`default_nettype wire

// ===== src/tgar_checker.sv =====
// Port-level checker for the tile gid to atlas rectangle block, bound to the top.
// Depends on tgar_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tgar_checker
    import tgar_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [2:0]               m_status,
    input  wire logic [SRC_W-1:0]         m_src_x,
    input  wire logic [SRC_W-1:0]         m_src_y,
    input  wire logic [F_W-1:0]           m_src_w,
    input  wire logic [DST_W-1:0]         m_dst_x,
    input  wire logic                     m_flip_h
);
    // A held result word keeps its status and position.
    `TGAR_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_dst_x))
    // Only defined status codes leave the block.
    `TGAR_ASSERT(a_status, m_valid |-> (m_status == ST_DRAW || m_status == ST_EMPTY || m_status == ST_NO_SET || m_status == ST_ZERO_COLS || m_status == ST_TABLE_OK || m_status == ST_FULL))
    // Words that draw nothing carry zero source position, source width and x destination, and no horizontal flip.
    `TGAR_ASSERT(a_nodraw, m_valid && m_status != ST_DRAW |-> m_src_x == '0 && m_src_y == '0 && m_src_w == '0 && m_dst_x == '0 && !m_flip_h)
    // Reset empties the pipe.
    `TGAR_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid)
endmodule

bind tile_gid_to_atlas_rect_top tgar_checker u_tgar_checker (.*);
`default_nettype wire

// ===== verif/tile_gid_to_atlas_rect_top_tb.sv =====
// Self-checking testbench for the tile gid to atlas rectangle block.
// Depends on tgar_pkg and the RTL top level tile_gid_to_atlas_rect_top.
`timescale 1ns / 100ps

// Expected result word of the block.
typedef struct {
    logic [2:0]         status;
    logic [25:0]        src_x;
    logic [25:0]        src_y;
    logic [11:0]        src_w;
    logic [11:0]        src_h;
    logic [35:0]        dst_x;
    logic [35:0]        dst_y;
    logic               flip_h;
    logic               flip_v;
} rect_word_t;

// Input word as the driver offers it.
typedef struct {
    logic [1:0]         opcode;
    logic [28:0]        first_gid;
    logic [11:0]        tile_w;
    logic [11:0]        tile_h;
    logic [11:0]        columns;
    logic [11:0]        margin;
    logic [11:0]        spacing;
    logic [31:0]        tile_word;
    logic signed [15:0] chunk_x;
    logic signed [15:0] chunk_y;
    logic [5:0]         local_x;
    logic [5:0]         local_y;
} tile_req_t;

// Mirrors the tileset table and the registers, and keeps the queue of
// expected rectangles in arrival order.
class atlas_scoreboard;
    logic [6:0]  chunk_size;
    logic [11:0] step_x;
    logic [11:0] step_y;
    int          n_sets;
    tile_req_t   sets[8];
    rect_word_t  pending_rects[$];
    int          n_errors;

    function void reset_state();
        chunk_size = 16;
        step_x = 16;
        step_y = 16;
        n_sets = 0;
        pending_rects.delete();
        n_errors = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [11:0] data);
        case (idx)
            tgar_pkg::CFG_CHUNK_SIZE:  chunk_size = data[6:0];
            tgar_pkg::CFG_GRID_STEP_X: step_x = data;
            tgar_pkg::CFG_GRID_STEP_Y: step_y = data;
            default: ;
        endcase
    endfunction

    function longint sat_src(longint v);
        return (v > 67108863) ? 67108863 : v;
    endfunction

    // Works out the result of one accepted input word.
    function void note_input(tile_req_t r);
        rect_word_t e;
        logic [28:0] gid;
        int sel;
        longint cs, cellx, celly, lidx, col, row;
        e = '{default: '0};
        gid = r.tile_word[28:0];
        sel = -1;
        case (r.opcode)
            tgar_pkg::OP_CLEAR: begin
                n_sets = 0;
                e.status = tgar_pkg::ST_TABLE_OK;
            end
            tgar_pkg::OP_APPEND: begin
                if (n_sets >= tgar_pkg::TILESET_SLOTS) begin
                    e.status = tgar_pkg::ST_FULL;
                end else begin
                    sets[n_sets] = r;
                    n_sets++;
                    e.status = tgar_pkg::ST_TABLE_OK;
                end
            end
            tgar_pkg::OP_TRANSLATE: begin
                for (int i = n_sets - 1; i >= 0 && sel < 0; i--)
                    if (gid >= sets[i].first_gid) sel = i;
                if (gid == 0) begin
                    e.status = tgar_pkg::ST_EMPTY;
                end else if (sel < 0) begin
                    e.status = tgar_pkg::ST_NO_SET;
                end else if (sets[sel].columns == 0) begin
                    e.status = tgar_pkg::ST_ZERO_COLS;
                end else begin
                    lidx = gid - sets[sel].first_gid;
                    col = lidx % sets[sel].columns;
                    row = lidx / sets[sel].columns;
                    cs = chunk_size;
                    if (cs < 1) cs = 1;
                    if (cs > tgar_pkg::MAX_CHUNK_SIZE) cs = tgar_pkg::MAX_CHUNK_SIZE;
                    cellx = longint'(r.chunk_x) * cs + r.local_x;
                    celly = longint'(r.chunk_y) * cs + r.local_y;
                    e.status = tgar_pkg::ST_DRAW;
                    e.src_x = 26'(sat_src(sets[sel].margin
                        + col * (sets[sel].tile_w + sets[sel].spacing)));
                    e.src_y = 26'(sat_src(sets[sel].margin
                        + row * (sets[sel].tile_h + sets[sel].spacing)));
                    e.src_w = sets[sel].tile_w;
                    e.src_h = sets[sel].tile_h;
                    e.dst_x = 36'(cellx * longint'(step_x));
                    e.dst_y = 36'(celly * longint'(step_y));
                    e.flip_h = r.tile_word[31];
                    e.flip_v = r.tile_word[30];
                end
            end
            default: e.status = tgar_pkg::ST_TABLE_OK;
        endcase
        pending_rects = {pending_rects, e};
    endfunction

    function void field(string nm, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, exp_v, act_v);
            n_errors++;
        end
    endfunction

    function void check_result(rect_word_t a);
        rect_word_t e;
        if (pending_rects.size() == 0) begin
            $display("%0t: unexpected result word, status %0d", $time, a.status);
            n_errors++;
            return;
        end
        e = pending_rects.pop_front();
        field("status", e.status, a.status);
        field("src_x", e.src_x, a.src_x);
        field("src_y", e.src_y, a.src_y);
        field("src_w", e.src_w, a.src_w);
        field("src_h", e.src_h, a.src_h);
        field("dst_x", e.dst_x, a.dst_x);
        field("dst_y", e.dst_y, a.dst_y);
        field("flip_h", e.flip_h, a.flip_h);
        field("flip_v", e.flip_v, a.flip_v);
    endfunction
endclass

module tile_gid_to_atlas_rect_top_tb;
    import tgar_pkg::*;

    // Settle wait for the drain, longer than the pipe is deep.
    localparam int PIPE_LATENCY = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    tile_req_t req = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    rect_word_t got;

    // Idle percentages for each side, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // When set, the receiver process holds m_ready low for a long stretch.
    bit hold_off_req = 1'b0;

    atlas_scoreboard sb = new();

    always #5 aclk = ~aclk;

    tile_gid_to_atlas_rect_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(req.opcode), .s_entry_first_gid(req.first_gid),
        .s_entry_tile_w(req.tile_w), .s_entry_tile_h(req.tile_h),
        .s_entry_columns(req.columns), .s_entry_margin(req.margin),
        .s_entry_spacing(req.spacing), .s_tile_word(req.tile_word),
        .s_chunk_x(req.chunk_x), .s_chunk_y(req.chunk_y),
        .s_local_x(req.local_x), .s_local_y(req.local_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(got.status), .m_src_x(got.src_x), .m_src_y(got.src_y),
        .m_src_w(got.src_w), .m_src_h(got.src_h),
        .m_dst_x(got.dst_x), .m_dst_y(got.dst_y),
        .m_flip_h(got.flip_h), .m_flip_v(got.flip_v)
    );

    // Result words are checked at the rising edge at which they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(got);
    end

    // The receiver updates its ready at each falling edge. A hold-off keeps it
    // low for a counted number of cycles while the sender keeps pushing.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && hold_left == 0) begin
                hold_left = 300;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one word, with a random idle gap first, and waits for acceptance.
    // Valid stays high on return so that words can follow back to back; idle
    // gaps and the drain lower it.
    task automatic send_word(tile_req_t r);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        req <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(r);
        @(negedge aclk);
    endtask

    // Writes one register; only called while the pipe is empty. Valid is
    // lowered by the next word or replaced by the next write.
    task automatic write_reg(cfg_index_t idx, logic [11:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_config(idx, data);
        @(negedge aclk);
    endtask

    // Waits until every expected word has come out, then lets the pipe settle.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (sb.pending_rects.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY) @(negedge aclk);
    endtask

    function automatic tile_req_t make_append(logic [28:0] fg, logic [11:0] w,
            logic [11:0] h, logic [11:0] cols, logic [11:0] mar, logic [11:0] sp);
        tile_req_t r;
        r = '{default: '0};
        r.opcode = OP_APPEND;
        r.first_gid = fg;
        r.tile_w = w;
        r.tile_h = h;
        r.columns = cols;
        r.margin = mar;
        r.spacing = sp;
        return r;
    endfunction

    function automatic tile_req_t make_translate(logic [31:0] word,
            logic signed [15:0] cx, logic signed [15:0] cy, logic [5:0] lx, logic [5:0] ly);
        tile_req_t r;
        r = '{default: '0};
        r.opcode = OP_TRANSLATE;
        r.tile_word = word;
        r.chunk_x = cx;
        r.chunk_y = cy;
        r.local_x = lx;
        r.local_y = ly;
        return r;
    endfunction

    // Random word: noise in every field, but mostly translates with gids near
    // the stored first gids so the lookup and divider are well exercised.
    function automatic tile_req_t random_word();
        tile_req_t r;
        int pick;
        r.opcode = 2'($urandom_range(3));
        r.first_gid = 29'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 3000));
        r.tile_w = 12'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 64));
        r.tile_h = 12'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 64));
        r.columns = ($urandom_range(15) == 0) ? 12'd0 :
                    12'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 40));
        r.margin = 12'($urandom);
        r.spacing = 12'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4));
        r.tile_word = $urandom;
        if ($urandom_range(3) != 0)
            r.tile_word[28:0] = 29'(($urandom_range(9) == 0) ? 0 : $urandom_range(0, 3500));
        r.chunk_x = 16'($urandom);
        r.chunk_y = 16'($urandom);
        r.local_x = 6'($urandom);
        r.local_y = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 70) r.opcode = OP_TRANSLATE;
        else if (pick < 88) r.opcode = OP_APPEND;
        else if (pick < 95) r.opcode = OP_CLEAR;
        else r.opcode = OP_NONE;
        return r;
    endfunction

    task automatic random_phase(int n_words);
        for (int i = 0; i < n_words; i++) send_word(random_word());
    endtask

    initial begin
        tile_req_t r;
        sb.reset_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty table, each status code and the field extremes.
        send_word(make_translate(32'h0000_0005, 0, 0, 0, 0));
        send_word(make_translate(32'hC000_0000, 0, 0, 0, 0));
        send_word(make_append(29'd100, 12'd16, 12'd16, 12'd8, 12'd2, 12'd1));
        send_word(make_translate(32'h0000_0063, 0, 0, 0, 0));
        send_word(make_translate(32'h8000_0064, 16'sd1, -16'sd1, 6'd63, 6'd0));
        send_word(make_append(29'd200, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0));
        send_word(make_translate(32'h4000_00C8, 0, 0, 0, 0));
        // Unsorted table: a lower first gid later in the table wins.
        send_word(make_append(29'd1, 12'd4095, 12'd4095, 12'd1, 12'd4095, 12'd4095));
        send_word(make_translate(32'hDFFF_FFFF, 16'sh7FFF, 16'sh8000, 6'd63, 6'd63));
        send_word(make_translate(32'h0000_00C8, 16'sh8000, 16'sh7FFF, 6'd0, 6'd63));
        send_word(make_append(29'h1FFF_FFFF, 12'd1, 12'd1, 12'd4095, 12'd0, 12'd0));
        send_word(make_translate(32'h1FFF_FFFF, -16'sd1, -16'sd1, 6'd1, 6'd1));
        for (int i = 0; i < 5; i++)
            send_word(make_append(29'(50 + i), 12'd8, 12'd8, 12'd4, 12'd0, 12'd0));
        r = '{default: '0};
        r.opcode = OP_NONE;
        send_word(r);
        r.opcode = OP_CLEAR;
        send_word(r);
        send_word(make_translate(32'h0000_0064, 0, 0, 0, 0));
        drain_pipe();

        // Register extremes, including out-of-range chunk sizes and zero steps.
        write_reg(CFG_CHUNK_SIZE, 12'd0);
        write_reg(CFG_GRID_STEP_X, 12'd0);
        write_reg(CFG_GRID_STEP_Y, 12'd4095);
        send_word(make_append(29'd1, 12'd16, 12'd16, 12'd16, 12'd0, 12'd0));
        send_word(make_translate(32'h0000_0011, 16'sh7FFF, 16'sh8000, 6'd63, 6'd63));
        drain_pipe();
        write_reg(CFG_CHUNK_SIZE, 12'd127);
        write_reg(CFG_GRID_STEP_X, 12'd4095);
        write_reg(CFG_GRID_STEP_Y, 12'd0);
        send_word(make_translate(32'h8000_0011, 16'sh8000, 16'sh7FFF, 6'd63, 6'd63));
        drain_pipe();

        // Sender idles often less than the receiver.
        send_idle_pct = 26;
        recv_idle_pct = 63;
        write_reg(CFG_CHUNK_SIZE, 12'd64);
        write_reg(CFG_GRID_STEP_X, 12'd1);
        write_reg(CFG_GRID_STEP_Y, 12'd1);
        random_phase(300);
        // Long hold-off on the result side while words keep coming.
        hold_off_req = 1'b1;
        random_phase(300);
        drain_pipe();

        // The other way round.
        send_idle_pct = 63;
        recv_idle_pct = 26;
        write_reg(CFG_CHUNK_SIZE, 12'd1);
        write_reg(CFG_GRID_STEP_X, 12'd37);
        write_reg(CFG_GRID_STEP_Y, 12'd4095);
        random_phase(600);
        drain_pipe();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_CHUNK_SIZE, 12'($urandom_range(1, 64)));
        write_reg(CFG_GRID_STEP_X, 12'($urandom_range(1, 4095)));
        write_reg(CFG_GRID_STEP_Y, 12'($urandom_range(1, 4095)));
        random_phase(600);
        drain_pipe();

        if (sb.n_errors == 0 && sb.pending_rects.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/tgar_pkg.sv
src/tile_gid_to_atlas_rect_top.sv
src/tgar_checker.sv
verif/tile_gid_to_atlas_rect_top_tb.sv
